// ===== design/hpds_pkg.sv =====
package hpds_pkg;

	// Configuration port geometry.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Default values of the module parameters.
	localparam int LINE_THRESHOLD_DEF = 650;
	localparam int SUM_WIDTH_DEF      = 24;

	// Reset values of the configuration registers.
	localparam logic [15:0] GAIN_P_RST          = 16'd2048;
	localparam logic [15:0] GAIN_I_RST          = 16'd6400;
	localparam logic [15:0] GAIN_D_RST          = 16'd8960;
	localparam logic [7:0]  SPEED_FLOOR_RST     = 8'd150;
	localparam logic [7:0]  SPEED_CEILING_RST   = 8'd180;
	localparam logic [12:0] HEADING_GOAL_RST    = 13'd0;
	localparam logic [14:0] TARGET_DISTANCE_RST = 15'd0;
	localparam logic        LINE_STOP_RST       = 1'b0;

	// Datapath widths fixed by the field formats.
	localparam int EA_W   = 14;  // heading error, Q4 degrees
	localparam int ED_W   = 21;  // wheel distance difference, Q4
	localparam int E_W    = 20;  // blended error, Q4
	localparam int DIFF_W = 21;  // error difference for the derivative term
	localparam int CORR_W = 16;  // correction in speed units
	localparam int SPD_W  = 8;   // wheel PWM speed
	localparam int MUL_B_W = 17; // second multiplier operand, gains plus a sign bit

	// Blend weights in 1/256 units.
	localparam logic signed [MUL_B_W-1:0] BLEND_A = 17'sd179;
	localparam logic signed [MUL_B_W-1:0] BLEND_D = 17'sd77;

	// Input command codes.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Register index on the configuration port.
	typedef enum logic [2:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_SPEED_FLOOR,
		REG_SPEED_CEILING,
		REG_HEADING_GOAL,
		REG_TARGET_DISTANCE,
		REG_LINE_STOP
	} reg_idx_t;

	// Configuration bundle handed from the register file to the sequencer.
	typedef struct packed {
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [7:0]  speed_floor;
		logic [7:0]  speed_ceiling;
		logic [12:0] heading_goal;
		logic [14:0] target_distance;
		logic        line_stop_en;
	} cfg_t;

endpackage

// ===== design/hpds_cfg.sv =====
module hpds_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hpds_pkg::ADDR_W-1:0] paddr,
	input  logic [hpds_pkg::DATA_W-1:0] pwdata,
	output logic [hpds_pkg::DATA_W-1:0] prdata,
	output hpds_pkg::cfg_t              cfg
);

	hpds_pkg::cfg_t     cfg_q;
	hpds_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx   = hpds_pkg::reg_idx_t'(paddr[hpds_pkg::ADDR_W-1:2]);
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	// Register writes complete in the access phase of a write transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p          <= hpds_pkg::GAIN_P_RST;
			cfg_q.gain_i          <= hpds_pkg::GAIN_I_RST;
			cfg_q.gain_d          <= hpds_pkg::GAIN_D_RST;
			cfg_q.speed_floor     <= hpds_pkg::SPEED_FLOOR_RST;
			cfg_q.speed_ceiling   <= hpds_pkg::SPEED_CEILING_RST;
			cfg_q.heading_goal    <= hpds_pkg::HEADING_GOAL_RST;
			cfg_q.target_distance <= hpds_pkg::TARGET_DISTANCE_RST;
			cfg_q.line_stop_en    <= hpds_pkg::LINE_STOP_RST;
		end else if (wr_en) begin
			unique case (idx)
				hpds_pkg::REG_GAIN_P:          cfg_q.gain_p          <= pwdata[15:0];
				hpds_pkg::REG_GAIN_I:          cfg_q.gain_i          <= pwdata[15:0];
				hpds_pkg::REG_GAIN_D:          cfg_q.gain_d          <= pwdata[15:0];
				hpds_pkg::REG_SPEED_FLOOR:     cfg_q.speed_floor     <= pwdata[7:0];
				hpds_pkg::REG_SPEED_CEILING:   cfg_q.speed_ceiling   <= pwdata[7:0];
				hpds_pkg::REG_HEADING_GOAL:    cfg_q.heading_goal    <= pwdata[12:0];
				hpds_pkg::REG_TARGET_DISTANCE: cfg_q.target_distance <= pwdata[14:0];
				hpds_pkg::REG_LINE_STOP:       cfg_q.line_stop_en    <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read data mux, zero-extended to the bus width.
	always_comb begin
		prdata = '0;
		unique case (idx)
			hpds_pkg::REG_GAIN_P:          prdata = 32'(cfg_q.gain_p);
			hpds_pkg::REG_GAIN_I:          prdata = 32'(cfg_q.gain_i);
			hpds_pkg::REG_GAIN_D:          prdata = 32'(cfg_q.gain_d);
			hpds_pkg::REG_SPEED_FLOOR:     prdata = 32'(cfg_q.speed_floor);
			hpds_pkg::REG_SPEED_CEILING:   prdata = 32'(cfg_q.speed_ceiling);
			hpds_pkg::REG_HEADING_GOAL:    prdata = 32'(cfg_q.heading_goal);
			hpds_pkg::REG_TARGET_DISTANCE: prdata = 32'(cfg_q.target_distance);
			hpds_pkg::REG_LINE_STOP:       prdata = 32'(cfg_q.line_stop_en);
			default:                       prdata = '0;
		endcase
	end

endmodule

// ===== design/hpds_mul.sv =====
module hpds_mul #(
	parameter int AW = 24,
	parameter int BW = 17
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	logic signed [AW+BW-1:0] p_q;

	// Signed multiply with the product registered.
	always_ff @(posedge clk) begin
		p_q <= (AW+BW)'(a) * (AW+BW)'(b);
	end

	assign p = p_q;

endmodule

// ===== design/hpds_seq.sv =====
module hpds_seq #(
	parameter int SUM_WIDTH      = hpds_pkg::SUM_WIDTH_DEF,
	parameter int LINE_THRESHOLD = hpds_pkg::LINE_THRESHOLD_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hpds_pkg::cfg_t            cfg,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      cmd,
	input  logic signed [12:0]        heading,
	input  logic signed [15:0]        travel_left,
	input  logic signed [15:0]        travel_right,
	input  logic [9:0]                sensor_left,
	input  logic [9:0]                sensor_right,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                speed_left,
	output logic [7:0]                speed_right,
	output logic signed [15:0]        correction,
	output logic                      done_res
);

	localparam int AW   = (SUM_WIDTH > hpds_pkg::DIFF_W) ? SUM_WIDTH : hpds_pkg::DIFF_W;
	localparam int BW   = hpds_pkg::MUL_B_W;
	localparam int PW   = AW + BW;
	localparam int ACW  = PW + 2;
	localparam int QW   = ACW - 12;
	localparam int EXT  = ((SUM_WIDTH > hpds_pkg::E_W) ? SUM_WIDTH : hpds_pkg::E_W) + 1;
	localparam int SPXW = hpds_pkg::CORR_W + 2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EA,
		S_ED,
		S_BLEND,
		S_INT,
		S_MI,
		S_MD,
		S_ACC,
		S_CORR,
		S_SPD,
		S_OUT
	} state_t;

	state_t state_q;

	// Latched input transaction.
	logic signed [12:0] heading_q;
	logic signed [15:0] tl_q;
	logic signed [15:0] tr_q;
	logic [9:0]         sl_q;
	logic [9:0]         sr_q;

	// Loop state and working registers.
	logic signed [SUM_WIDTH-1:0]          sum_q;
	logic signed [hpds_pkg::E_W-1:0]      last_q;
	logic signed [hpds_pkg::E_W-1:0]      e_q;
	logic signed [hpds_pkg::DIFF_W-1:0]   diff_q;
	logic signed [ACW-1:0]                acc_q;
	logic signed [hpds_pkg::CORR_W-1:0]   corr_q;
	logic                                 done_q;
	logic [hpds_pkg::SPD_W-1:0]           lspd_q;
	logic [hpds_pkg::SPD_W-1:0]           rspd_q;

	// Output register.
	logic                                 out_valid_q;
	logic [7:0]                           speed_left_q;
	logic [7:0]                           speed_right_q;
	logic signed [15:0]                   correction_q;
	logic                                 done_res_q;

	logic                                 in_acc;
	logic                                 out_free;
	logic signed [12:0]                   tgt_head;
	logic signed [hpds_pkg::EA_W-1:0]     ea;
	logic signed [16:0]                   tdiff;
	logic signed [hpds_pkg::ED_W-1:0]     ed;
	logic signed [AW-1:0]                 mul_a;
	logic signed [BW-1:0]                 mul_b;
	logic signed [PW-1:0]                 prod;
	logic signed [ACW-1:0]                acc_plus;
	logic signed [EXT-1:0]                sum_ext;
	logic signed [SUM_WIDTH-1:0]          sum_sat;
	logic signed [ACW-1:0]                acc_adj;
	logic signed [QW-1:0]                 quot;
	logic signed [hpds_pkg::CORR_W-1:0]   corr_sat;
	logic signed [SPXW-1:0]               r_raw;
	logic signed [SPXW-1:0]               l_raw;
	logic [hpds_pkg::SPD_W-1:0]           r_clamped;
	logic [hpds_pkg::SPD_W-1:0]           l_clamped;
	logic                                 dist_hit;
	logic                                 line_hit;

	// Speed clamp: the floor test wins over the ceiling test.
	function automatic logic [hpds_pkg::SPD_W-1:0] clamp_speed(
		input logic signed [SPXW-1:0] x,
		input logic [7:0]             lo,
		input logic [7:0]             hi
	);
		logic signed [SPXW-1:0] lo_x;
		logic signed [SPXW-1:0] hi_x;
		lo_x = $signed({{(SPXW-8){1'b0}}, lo});
		hi_x = $signed({{(SPXW-8){1'b0}}, hi});
		if (x < lo_x) begin
			clamp_speed = lo;
		end else if (x > hi_x) begin
			clamp_speed = hi;
		end else begin
			clamp_speed = x[hpds_pkg::SPD_W-1:0];
		end
	endfunction

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	// Error terms from the latched transaction.
	assign tgt_head = cfg.heading_goal;
	assign ea       = hpds_pkg::EA_W'(tgt_head) - hpds_pkg::EA_W'(heading_q);
	assign tdiff    = 17'(tl_q) - 17'(tr_q);
	assign ed       = {tdiff, 4'b0000};

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_EA: begin
				mul_a = AW'(ea);
				mul_b = hpds_pkg::BLEND_A;
			end
			S_ED: begin
				mul_a = AW'(ed);
				mul_b = hpds_pkg::BLEND_D;
			end
			S_INT: begin
				mul_a = AW'(e_q);
				mul_b = $signed({1'b0, cfg.gain_p});
			end
			S_MI: begin
				mul_a = AW'(sum_q);
				mul_b = $signed({1'b0, cfg.gain_i});
			end
			S_MD: begin
				mul_a = AW'(diff_q);
				mul_b = $signed({1'b0, cfg.gain_d});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	hpds_mul #(
		.AW(AW),
		.BW(BW)
	) u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p  (prod)
	);

	assign acc_plus = acc_q + ACW'(prod);

	// Integral update, saturated to the accumulator width.
	always_comb begin
		sum_ext = EXT'(sum_q) + EXT'(e_q);
		if ((&sum_ext[EXT-1:SUM_WIDTH-1]) | ~(|sum_ext[EXT-1:SUM_WIDTH-1])) begin
			sum_sat = sum_ext[SUM_WIDTH-1:0];
		end else begin
			sum_sat = {sum_ext[EXT-1], {(SUM_WIDTH-1){~sum_ext[EXT-1]}}};
		end
	end

	// Divide by 4096 toward zero, then saturate to the correction width.
	always_comb begin
		acc_adj = acc_q + (acc_q[ACW-1] ? ACW'(4095) : ACW'(0));
		quot    = acc_adj[ACW-1:12];
		if ((&quot[QW-1:hpds_pkg::CORR_W-1]) | ~(|quot[QW-1:hpds_pkg::CORR_W-1])) begin
			corr_sat = quot[hpds_pkg::CORR_W-1:0];
		end else begin
			corr_sat = {quot[QW-1], {(hpds_pkg::CORR_W-1){~quot[QW-1]}}};
		end
	end

	// Wheel speed update and finish test.
	assign r_raw     = $signed({{(SPXW-8){1'b0}}, rspd_q}) + SPXW'(corr_q);
	assign l_raw     = $signed({{(SPXW-8){1'b0}}, lspd_q}) - SPXW'(corr_q);
	assign r_clamped = clamp_speed(r_raw, cfg.speed_floor, cfg.speed_ceiling);
	assign l_clamped = clamp_speed(l_raw, cfg.speed_floor, cfg.speed_ceiling);
	assign dist_hit  = (17'(tl_q) >= $signed({2'b00, cfg.target_distance}))
		&& (17'(tr_q) >= $signed({2'b00, cfg.target_distance}));
	assign line_hit  = cfg.line_stop_en
		&& ((sl_q > 10'(LINE_THRESHOLD)) || (sr_q > 10'(LINE_THRESHOLD)));

	// Sequencer, loop state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			sum_q         <= '0;
			last_q        <= '0;
			lspd_q        <= hpds_pkg::SPEED_FLOOR_RST;
			rspd_q        <= hpds_pkg::SPEED_FLOOR_RST;
			out_valid_q   <= 1'b0;
			speed_left_q  <= '0;
			speed_right_q <= '0;
			correction_q  <= '0;
			done_res_q    <= 1'b0;
		end else begin
			// A finished result loads the output register once it is free.
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (cmd == hpds_pkg::CMD_START) begin
							sum_q   <= '0;
							last_q  <= '0;
							lspd_q  <= cfg.speed_floor;
							rspd_q  <= cfg.speed_floor;
							state_q <= S_OUT;
						end else begin
							state_q <= S_EA;
						end
					end
				end
				S_EA:    state_q <= S_ED;
				S_ED:    state_q <= S_BLEND;
				S_BLEND: state_q <= S_INT;
				S_INT: begin
					sum_q   <= sum_sat;
					last_q  <= e_q;
					state_q <= S_MI;
				end
				S_MI:    state_q <= S_MD;
				S_MD:    state_q <= S_ACC;
				S_ACC:   state_q <= S_CORR;
				S_CORR:  state_q <= S_SPD;
				S_SPD: begin
					lspd_q  <= l_clamped;
					rspd_q  <= r_clamped;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						speed_left_q  <= lspd_q;
						speed_right_q <= rspd_q;
						correction_q  <= corr_q;
						done_res_q    <= done_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					heading_q <= heading;
					tl_q      <= travel_left;
					tr_q      <= travel_right;
					sl_q      <= sensor_left;
					sr_q      <= sensor_right;
					corr_q    <= '0;
					done_q    <= 1'b0;
				end
			end
			S_ED:    acc_q  <= ACW'(prod);
			S_BLEND: e_q    <= acc_plus[hpds_pkg::E_W+7:8];
			S_INT:   diff_q <= hpds_pkg::DIFF_W'(e_q) - hpds_pkg::DIFF_W'(last_q);
			S_MI:    acc_q  <= ACW'(prod);
			S_MD:    acc_q  <= acc_plus;
			S_ACC:   acc_q  <= acc_plus;
			S_CORR:  corr_q <= corr_sat;
			S_SPD:   done_q <= dist_hit | line_hit;
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign speed_left  = speed_left_q;
	assign speed_right = speed_right_q;
	assign correction  = correction_q;
	assign done_res    = done_res_q;

endmodule

// ===== design/heading_pid_drive_steering.sv =====
// Heading-hold PID steering for a two-wheel differential drive.
// Configuration registers (gains, speed limits, target heading and distance,
// line stop enable) are written over the APB-style port; the user must do so
// only while idle, as the block does not enforce it. pready is always high.
// The input channel carries one command per transaction: a start command
// clears the integral and previous error and loads both wheel speeds with the
// speed floor, a step command runs one control update. Every input transaction
// gives exactly one output transaction with both wheel speeds, the correction
// and the done flag.
// Reads return the register value. A step command runs through the states EA,
// ED, BLEND, INT, MI, MD, ACC, CORR, SPD and OUT, as the single shared
// multiplier is used five times with a registered product, followed by adds;
// a start command goes straight to OUT. in_stall stays high while an item is
// at work. The result is loaded into the output register in state OUT.
// The output register holds a finished result while out_stall is high; the
// next item may be accepted meanwhile, and its result waits in the sequencer
// until the output register is free.
// Reset restores the register defaults, clears the loop state and sets both
// wheel speeds to 150.
module heading_pid_drive_steering #(
	parameter int SUM_WIDTH      = hpds_pkg::SUM_WIDTH_DEF,
	parameter int LINE_THRESHOLD = hpds_pkg::LINE_THRESHOLD_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hpds_pkg::ADDR_W-1:0] paddr,
	input  logic [hpds_pkg::DATA_W-1:0] pwdata,
	output logic [hpds_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic signed [12:0]          heading,
	input  logic signed [15:0]          travel_left,
	input  logic signed [15:0]          travel_right,
	input  logic [9:0]                  sensor_left,
	input  logic [9:0]                  sensor_right,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  speed_left,
	output logic [7:0]                  speed_right,
	output logic signed [15:0]          correction,
	output logic                        done_res
);

	hpds_pkg::cfg_t cfg;

	assign pready = 1'b1;

	// Configuration register file.
	hpds_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	// Control loop sequencer around the shared multiplier.
	hpds_seq #(
		.SUM_WIDTH     (SUM_WIDTH),
		.LINE_THRESHOLD(LINE_THRESHOLD)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.heading     (heading),
		.travel_left (travel_left),
		.travel_right(travel_right),
		.sensor_left (sensor_left),
		.sensor_right(sensor_right),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.speed_left  (speed_left),
		.speed_right (speed_right),
		.correction  (correction),
		.done_res    (done_res)
	);

endmodule
